>>> src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, microinstruction codes and types of the bit-slice ALU.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // Slice geometry
    localparam int SLICE_WIDTH = 4;
    localparam int NUM_REGS    = 16;
    localparam int ADDR_W      = 4;
    localparam int SEL_W       = 3;

    // Stream widths: 23 payload bits padded to 3 bytes, 8 result bits
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Source operand pair (R,S)
    localparam logic [SEL_W-1:0] SRC_AQ = 3'd0;
    localparam logic [SEL_W-1:0] SRC_AB = 3'd1;
    localparam logic [SEL_W-1:0] SRC_ZQ = 3'd2;
    localparam logic [SEL_W-1:0] SRC_ZB = 3'd3;
    localparam logic [SEL_W-1:0] SRC_ZA = 3'd4;
    localparam logic [SEL_W-1:0] SRC_DA = 3'd5;
    localparam logic [SEL_W-1:0] SRC_DQ = 3'd6;
    localparam logic [SEL_W-1:0] SRC_DZ = 3'd7;

    // ALU function
    localparam logic [SEL_W-1:0] OP_ADD  = 3'd0;
    localparam logic [SEL_W-1:0] OP_SUBR = 3'd1;
    localparam logic [SEL_W-1:0] OP_SUBS = 3'd2;
    localparam logic [SEL_W-1:0] OP_OR   = 3'd3;
    localparam logic [SEL_W-1:0] OP_AND  = 3'd4;
    localparam logic [SEL_W-1:0] OP_NOTRS = 3'd5;
    localparam logic [SEL_W-1:0] OP_XOR  = 3'd6;
    localparam logic [SEL_W-1:0] OP_XNOR = 3'd7;

    // Destination control
    localparam logic [SEL_W-1:0] DST_QREG  = 3'd0;
    localparam logic [SEL_W-1:0] DST_NOP   = 3'd1;
    localparam logic [SEL_W-1:0] DST_RAMA  = 3'd2;
    localparam logic [SEL_W-1:0] DST_RAMF  = 3'd3;
    localparam logic [SEL_W-1:0] DST_RAMQD = 3'd4;
    localparam logic [SEL_W-1:0] DST_RAMD  = 3'd5;
    localparam logic [SEL_W-1:0] DST_RAMQU = 3'd6;
    localparam logic [SEL_W-1:0] DST_RAMU  = 3'd7;

    // Register file write port
    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [SLICE_WIDTH-1:0] data;
    } bsa_wr_t;

    // ALU result and flags
    typedef struct packed {
        logic [SLICE_WIDTH-1:0] f;
        logic                   c4;
        logic                   ovr;
    } bsa_alu_res_t;

endpackage

>>> src/bsa_regfile.sv
// ----------------------------------------------------------------------------
// bsa_regfile
// 16 x 4 register file: one write port, two registered read ports with
// write-through bypass, and per-entry valid bits so unwritten entries read 0.
// ----------------------------------------------------------------------------
module bsa_regfile
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [bsa_pkg::ADDR_W-1:0]      rd_addr_a,
    input  logic [bsa_pkg::ADDR_W-1:0]      rd_addr_b,
    input  bsa_pkg::bsa_wr_t                wr,
    output logic [bsa_pkg::SLICE_WIDTH-1:0] rd_data_a,
    output logic [bsa_pkg::SLICE_WIDTH-1:0] rd_data_b
);

    logic [bsa_pkg::SLICE_WIDTH-1:0] mem [bsa_pkg::NUM_REGS];
    logic [bsa_pkg::NUM_REGS-1:0]    valid_reg;
    logic [bsa_pkg::SLICE_WIDTH-1:0] rd_a_reg;
    logic [bsa_pkg::SLICE_WIDTH-1:0] rd_b_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Written-entry marks, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Registered reads; a write on the same edge is passed through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr_a))
                rd_a_reg <= wr.data;
            else if (valid_reg[rd_addr_a])
                rd_a_reg <= mem[rd_addr_a];
            else
                rd_a_reg <= '0;

            if (wr.en && (wr.addr == rd_addr_b))
                rd_b_reg <= wr.data;
            else if (valid_reg[rd_addr_b])
                rd_b_reg <= mem[rd_addr_b];
            else
                rd_b_reg <= '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> src/bsa_alu.sv
// ----------------------------------------------------------------------------
// bsa_alu
// Operand source selection and the eight ALU functions with C4/OVR flags.
// ----------------------------------------------------------------------------
module bsa_alu
(
    input  logic [bsa_pkg::SEL_W-1:0]       source_sel,
    input  logic [bsa_pkg::SEL_W-1:0]       op,
    input  logic                            carry_in,
    input  logic [bsa_pkg::SLICE_WIDTH-1:0] reg_a,
    input  logic [bsa_pkg::SLICE_WIDTH-1:0] reg_b,
    input  logic [bsa_pkg::SLICE_WIDTH-1:0] q_val,
    input  logic [bsa_pkg::SLICE_WIDTH-1:0] data_in,
    output bsa_pkg::bsa_alu_res_t           res
);

    localparam int W = bsa_pkg::SLICE_WIDTH;

    logic [W-1:0] r;
    logic [W-1:0] s;
    logic [W-1:0] x;
    logic [W-1:0] z;
    logic [W:0]   sum;
    logic [W-1:0] low;
    logic [W-1:0] ri;
    logic [W-1:0] p;
    logic [W-1:0] g;
    logic         lo;
    logic         hi;

    // Source operand pair
    always_comb
    begin
        case (source_sel)
            bsa_pkg::SRC_AQ: begin r = reg_a;   s = q_val; end
            bsa_pkg::SRC_AB: begin r = reg_a;   s = reg_b; end
            bsa_pkg::SRC_ZQ: begin r = '0;      s = q_val; end
            bsa_pkg::SRC_ZB: begin r = '0;      s = reg_b; end
            bsa_pkg::SRC_ZA: begin r = '0;      s = reg_a; end
            bsa_pkg::SRC_DA: begin r = data_in; s = reg_a; end
            bsa_pkg::SRC_DQ: begin r = data_in; s = q_val; end
            default:         begin r = data_in; s = '0;    end
        endcase
    end

    // Adder operands: subtraction adds the complement
    always_comb
    begin
        x = r;
        z = s;
        if (op == bsa_pkg::OP_SUBR)
        begin
            x = s;
            z = ~r;
        end
        else if (op == bsa_pkg::OP_SUBS)
        begin
            z = ~s;
        end
        sum = {1'b0, x} + {1'b0, z} + {{W{1'b0}}, carry_in};
        low = {1'b0, x[W-2:0]} + {1'b0, z[W-2:0]} + {{(W-1){1'b0}}, carry_in};
    end

    // Logic-mode propagate/generate; notR-and-S and xor use inverted R
    assign ri = ((op == bsa_pkg::OP_NOTRS) || (op == bsa_pkg::OP_XOR)) ? ~r : r;
    assign p  = ri | s;
    assign g  = ri & s;

    // Overflow halves of the published xnor-mode equation
    assign lo = ~p[2] | (~g[2] & ~p[1]) | (~g[2] & ~g[1] & ~p[0])
              | (~g[2] & ~g[1] & ~g[0] & carry_in);
    assign hi = ~p[3] | (~g[3] & ~p[2]) | (~g[3] & ~g[2] & ~p[1])
              | (~g[3] & ~g[2] & ~g[1] & ~p[0])
              | (~g[3] & ~g[2] & ~g[1] & ~g[0] & carry_in);

    // Function result and flags
    always_comb
    begin
        res = '0;
        case (op)
            bsa_pkg::OP_ADD, bsa_pkg::OP_SUBR, bsa_pkg::OP_SUBS:
            begin
                res.f   = sum[W-1:0];
                res.c4  = sum[W];
                res.ovr = low[W-1] ^ sum[W];
            end
            bsa_pkg::OP_OR:
            begin
                // C4 = ~(P3 P2 P1 P0) + Cn
                res.f   = r | s;
                res.c4  = ~(&p) | carry_in;
                res.ovr = ~(&p) | carry_in;
            end
            bsa_pkg::OP_AND, bsa_pkg::OP_NOTRS:
            begin
                // C4 = G3 + G2 + G1 + G0 + Cn
                res.f   = (op == bsa_pkg::OP_AND) ? (r & s) : (~r & s);
                res.c4  = (|g) | carry_in;
                res.ovr = (|g) | carry_in;
            end
            default:
            begin
                // C4 = ~(G3 + P3G2 + P3P2G1 + P3P2P1P0(G0 + ~Cn))
                res.f   = (op == bsa_pkg::OP_XOR) ? (r ^ s) : ~(r ^ s);
                res.c4  = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
                          | (p[3] & p[2] & p[1] & p[0] & (g[0] | ~carry_in)));
                res.ovr = lo ^ hi;
            end
        endcase
    end

endmodule

>>> src/bit_slice_alu_4bit.sv
// ----------------------------------------------------------------------------
// bit_slice_alu_4bit
// A 4-bit bit-slice ALU with a 16-entry register file and a Q register. It
// takes one microinstruction transaction per clock while the result side
// is not stalled and returns one result transaction for each: the register
// file is first read into the input register stage, then the ALU computes
// and writes the register file, Q and the result register. Register file
// and Q writes of one microinstruction are seen by the next one with no
// gap. With out_enable low the result fields are all zero while the state
// still updates. A stall on the result side holds the input side after one
// more transaction.
// ----------------------------------------------------------------------------
module bit_slice_alu_4bit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // source_sel[2:0] op[5:3] dest_sel[8:6] addr_a[12:9] addr_b[16:13]
    // data_in[20:17] carry_in[21] out_enable[22] zero pad[23]
    input  logic [bsa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // y_out[3:0] zero_flag[4] sign_flag[5] carry_out[6] overflow_flag[7]
    output logic [bsa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    localparam int W  = bsa_pkg::SLICE_WIDTH;
    localparam int SW = bsa_pkg::SEL_W;
    localparam int AW = bsa_pkg::ADDR_W;

    // Input field unpacking
    logic [SW-1:0] in_src;
    logic [SW-1:0] in_op;
    logic [SW-1:0] in_dst;
    logic [AW-1:0] in_addr_a;
    logic [AW-1:0] in_addr_b;
    logic [W-1:0]  in_d;
    logic          in_cn;
    logic          in_oe;

    assign in_src    = s_tdata[2:0];
    assign in_op     = s_tdata[5:3];
    assign in_dst    = s_tdata[8:6];
    assign in_addr_a = s_tdata[12:9];
    assign in_addr_b = s_tdata[16:13];
    assign in_d      = s_tdata[20:17];
    assign in_cn     = s_tdata[21];
    assign in_oe     = s_tdata[22];

    // Pipeline registers
    logic          s1_valid_reg;
    logic [SW-1:0] s1_src_reg;
    logic [SW-1:0] s1_op_reg;
    logic [SW-1:0] s1_dst_reg;
    logic [AW-1:0] s1_addr_b_reg;
    logic [W-1:0]  s1_d_reg;
    logic          s1_cn_reg;
    logic          s1_oe_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  q_next;
    logic          out_valid_reg;
    logic [bsa_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [bsa_pkg::M_TDATA_W-1:0] out_data_next;

    logic                  accept;
    logic                  advance;
    logic [W-1:0]          reg_a;
    logic [W-1:0]          reg_b;
    logic [W-1:0]          y_val;
    bsa_pkg::bsa_wr_t      wr;
    bsa_pkg::bsa_alu_res_t alu_res;

    // Handshake control
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Register file
    bsa_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (in_addr_a),
        .rd_addr_b (in_addr_b),
        .wr        (wr),
        .rd_data_a (reg_a),
        .rd_data_b (reg_b)
    );

    // ALU
    bsa_alu u_alu
    (
        .source_sel (s1_src_reg),
        .op         (s1_op_reg),
        .carry_in   (s1_cn_reg),
        .reg_a      (reg_a),
        .reg_b      (reg_b),
        .q_val      (q_reg),
        .data_in    (s1_d_reg),
        .res        (alu_res)
    );

    // Destination decode: register B, Q and Y
    always_comb
    begin
        wr.en   = advance;
        wr.addr = s1_addr_b_reg;
        wr.data = alu_res.f;
        q_next  = q_reg;
        y_val   = alu_res.f;
        case (s1_dst_reg)
            bsa_pkg::DST_QREG:
            begin
                wr.en  = 1'b0;
                q_next = alu_res.f;
            end
            bsa_pkg::DST_NOP:
            begin
                wr.en = 1'b0;
            end
            bsa_pkg::DST_RAMA:
            begin
                y_val = reg_a;
            end
            bsa_pkg::DST_RAMF:
            begin
                wr.data = alu_res.f;
            end
            bsa_pkg::DST_RAMQD:
            begin
                wr.data = {1'b0, alu_res.f[W-1:1]};
                q_next  = {1'b0, q_reg[W-1:1]};
            end
            bsa_pkg::DST_RAMD:
            begin
                wr.data = {1'b0, alu_res.f[W-1:1]};
            end
            bsa_pkg::DST_RAMQU:
            begin
                wr.data = {alu_res.f[W-2:0], 1'b0};
                q_next  = {q_reg[W-2:0], 1'b0};
            end
            default:
            begin
                wr.data = {alu_res.f[W-2:0], 1'b0};
            end
        endcase
    end

    // Result packing, gated by output enable
    always_comb
    begin
        if (s1_oe_reg)
            out_data_next = {alu_res.ovr, alu_res.c4, alu_res.f[W-1],
                             (alu_res.f == '0), y_val};
        else
            out_data_next = '0;
    end

    // Input register stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Input register stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg    <= in_src;
            s1_op_reg     <= in_op;
            s1_dst_reg    <= in_dst;
            s1_addr_b_reg <= in_addr_b;
            s1_d_reg      <= in_d;
            s1_cn_reg     <= in_cn;
            s1_oe_reg     <= in_oe;
        end
    end

    // Q register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (advance)
        begin
            q_reg <= q_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A new transaction into a full input stage must move that stage on
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> advance)
        else $error("input stage overwritten before it moved on");

    // Every advance leaves a result waiting
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advance did not produce a result");

    // Q load takes the ALU result
    a_q_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_dst_reg == bsa_pkg::DST_QREG)) |=> (q_reg == $past(alu_res.f)))
        else $error("Q register did not load F");

    // Zero result never carries a sign bit
    a_zero_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> !m_tdata[5])
        else $error("zero and sign flags both set");
`endif

endmodule
